/* sv/serial_command_parser_unit_assert.svh */
// Assertion macros for the checker file of the serial command parser.
`ifndef SERIAL_COMMAND_PARSER_UNIT_ASSERT_SVH
`define SERIAL_COMMAND_PARSER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("serial command parser assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("serial command parser assertion failed");

`endif

/* sv/scp_pkg.sv */
package scp_pkg;

  typedef enum logic [2:0] {
    ST_HUNT = 3'd0,
    ST_REQ1 = 3'd1,
    ST_REQ2 = 3'd2,
    ST_CMD1 = 3'd3,
    ST_CMD2 = 3'd4,
    ST_PKT  = 3'd5
  } parse_st_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_REQUEST  = 2'd1,
    EV_DISABLED = 2'd2,
    EV_PACKET   = 2'd3
  } event_t;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_V      = 8'h76;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_N      = 8'h4E;

  localparam logic [3:0] IDX_CTRL     = 4'd0;
  localparam logic [3:0] IDX_PITCH_LO = 4'd1;
  localparam logic [3:0] IDX_PITCH_HI = 4'd2;
  localparam logic [3:0] IDX_ROLL_LO  = 4'd3;
  localparam logic [3:0] IDX_ROLL_HI  = 4'd4;
  localparam logic [3:0] IDX_YAW_LO   = 4'd5;
  localparam logic [3:0] IDX_YAW_HI   = 4'd6;
  localparam logic [3:0] IDX_THR_LO   = 4'd7;
  localparam logic [3:0] IDX_THR_HI   = 4'd8;
  localparam logic [3:0] IDX_LAST     = 4'd9;

  localparam logic signed [15:0] ATT_MAX    = 16'sd2000;
  localparam logic signed [15:0] ATT_MIN    = -16'sd2000;
  localparam logic signed [15:0] YAW_MAX    = 16'sd1500;
  localparam logic signed [15:0] YAW_MIN    = -16'sd1500;
  localparam logic signed [15:0] THRUST_MAX = 16'sd3200;
  localparam logic signed [15:0] THRUST_MIN = 16'sd0;

  localparam int NUM_IDS = 4;

  localparam logic [7:0] RC_ID_RST     = 8'd1;
  localparam logic [7:0] STATE_ID_RST  = 8'd2;
  localparam logic [7:0] SENSOR_ID_RST = 8'd3;
  localparam logic [7:0] AUX_ID_RST    = 8'd4;

  typedef logic [NUM_IDS-1:0][7:0] req_ids_t;

  typedef struct packed {
    parse_st_t   pst;
    logic        verbose;
    logic [3:0]  idx;
    logic        enable;
    logic [7:0]  ctrl;
    logic [11:0] pitch;
    logic [11:0] roll;
    logic [11:0] yaw;
    logic [11:0] thrust;
  } scp_state_t;

  typedef struct packed {
    event_t     ev;
    logic [1:0] rtype;
    logic       rverb;
  } scp_res_t;

  function automatic logic [11:0] clamp12(logic signed [15:0] v,
                                          logic signed [15:0] lo,
                                          logic signed [15:0] hi);
    logic signed [15:0] t;
    t = v;
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    return t[11:0];
  endfunction

endpackage

/* sv/scp_step.sv */
module scp_step (
  input  scp_pkg::scp_state_t st_i,
  input  logic [7:0]          rx_byte,
  input  scp_pkg::req_ids_t   ids,
  output scp_pkg::scp_state_t st_o,
  output scp_pkg::scp_res_t   res_o
);
  import scp_pkg::*;

  logic               hit;
  logic [1:0]         hit_k;
  logic signed [15:0] pitch_w;
  logic signed [15:0] roll_w;
  logic signed [15:0] yaw_w;
  logic signed [15:0] thr_w;

  always_comb begin
    hit   = 1'b0;
    hit_k = 2'd0;
    for (int k = NUM_IDS - 1; k >= 0; k--) begin
      if (rx_byte == ids[k]) begin
        hit   = 1'b1;
        hit_k = 2'(k);
      end
    end
  end

  always_comb begin
    pitch_w = {{4{st_i.pitch[11]}}, st_i.pitch};
    roll_w  = {{4{st_i.roll[11]}}, st_i.roll};
    yaw_w   = {{4{st_i.yaw[11]}}, st_i.yaw};
    thr_w   = {4'b0000, st_i.thrust};
    unique case (st_i.idx)
      IDX_PITCH_LO: pitch_w[7:0]  = rx_byte;
      IDX_PITCH_HI: pitch_w[15:8] = rx_byte;
      IDX_ROLL_LO:  roll_w[7:0]   = rx_byte;
      IDX_ROLL_HI:  roll_w[15:8]  = rx_byte;
      IDX_YAW_LO:   yaw_w[7:0]    = rx_byte;
      IDX_YAW_HI:   yaw_w[15:8]   = rx_byte;
      IDX_THR_LO:   thr_w[7:0]    = rx_byte;
      IDX_THR_HI:   thr_w[15:8]   = rx_byte;
      default: ;
    endcase
  end

  always_comb begin
    st_o        = st_i;
    res_o.ev    = EV_NONE;
    res_o.rtype = 2'd0;
    res_o.rverb = 1'b0;
    unique case (st_i.pst)
      ST_HUNT: begin
        if (rx_byte == CH_DOLLAR) begin
          st_o.pst = ST_REQ1;
        end else if (rx_byte == CH_HASH) begin
          st_o.pst = ST_CMD1;
        end
      end
      ST_REQ1: st_o.pst = (rx_byte == CH_GT) ? ST_REQ2 : ST_HUNT;
      ST_REQ2: begin
        if (rx_byte == CH_V && !st_i.verbose) begin
          st_o.verbose = 1'b1;
        end else begin
          if (hit) begin
            res_o.ev     = EV_REQUEST;
            res_o.rtype  = hit_k;
            res_o.rverb  = st_i.verbose;
            st_o.verbose = 1'b0;
          end
          st_o.pst = ST_HUNT;
        end
      end
      ST_CMD1: st_o.pst = (rx_byte == CH_GT) ? ST_CMD2 : ST_HUNT;
      ST_CMD2: begin
        if (rx_byte == CH_D) begin
          st_o.enable = 1'b0;
          res_o.ev    = EV_DISABLED;
          st_o.pst    = ST_HUNT;
        end else if (rx_byte == CH_N) begin
          st_o.pst = ST_PKT;
        end else begin
          st_o.pst = ST_HUNT;
        end
        st_o.idx = 4'd0;
      end
      ST_PKT: begin
        st_o.enable = 1'b1;
        if (st_i.idx == IDX_CTRL) begin
          st_o.ctrl = rx_byte;
        end
        if (st_i.idx == IDX_LAST) begin
          st_o.pst = ST_HUNT;
          res_o.ev = EV_PACKET;
        end
        st_o.pitch  = clamp12(pitch_w, ATT_MIN, ATT_MAX);
        st_o.roll   = clamp12(roll_w, ATT_MIN, ATT_MAX);
        st_o.yaw    = clamp12(yaw_w, YAW_MIN, YAW_MAX);
        st_o.thrust = clamp12(thr_w, THRUST_MIN, THRUST_MAX);
        st_o.idx    = st_i.idx + 4'd1;
      end
      default: st_o.pst = ST_HUNT;
    endcase
  end

endmodule

/* sv/serial_command_parser_unit.sv */
// A word accepted into the input register moves on to the result register,
// where it waits until the receiver takes it.
// Throughput: one word per cycle while out_stall is low; the input and result
// registers let a new word enter while a finished result still waits on out_stall.
// Reset is synchronous and active low: the parser returns to hunting, all
// flags and setpoints clear, and the request ids load 1, 2, 3 and 4.
module serial_command_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_event_res,
  output logic [1:0]         out_request_type,
  output logic               out_request_verbose,
  output logic               out_control_enabled,
  output logic [7:0]         out_ctrl_word,
  output logic signed [11:0] out_pitch_cmd,
  output logic signed [11:0] out_roll_cmd,
  output logic signed [11:0] out_yaw_cmd,
  output logic [11:0]        out_thrust_cmd,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import scp_pkg::*;

  logic       in_valid_r;
  logic       in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  scp_res_t   res_r;
  scp_res_t   res_nxt;
  scp_state_t state_r;
  scp_state_t state_nxt;
  req_ids_t   ids_r;
  logic       advance;
  logic       accept_in;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {24'd0, ids_r[paddr[3:2]]};

  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && out_valid_r && out_stall;
  assign accept_in = in_valid && !in_stall;

  scp_step u_step (
    .st_i    (state_r),
    .rx_byte (in_byte_r),
    .ids     (ids_r),
    .st_o    (state_nxt),
    .res_o   (res_nxt)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept_in) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      state_r        <= '{pst: ST_HUNT, default: '0};
      ids_r[0]       <= RC_ID_RST;
      ids_r[1]       <= STATE_ID_RST;
      ids_r[2]       <= SENSOR_ID_RST;
      ids_r[3]       <= AUX_ID_RST;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= state_nxt;
      end
      if (cfg_write) begin
        ids_r[paddr[3:2]] <= pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      in_byte_r <= in_rx_byte;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  // The state only moves when a word enters the result register, so the
  // stored setpoints always belong to the word on display.
  assign out_valid           = out_valid_r;
  assign out_event_res       = res_r.ev;
  assign out_request_type    = res_r.rtype;
  assign out_request_verbose = res_r.rverb;
  assign out_control_enabled = state_r.enable;
  assign out_ctrl_word       = state_r.ctrl;
  assign out_pitch_cmd       = state_r.pitch;
  assign out_roll_cmd        = state_r.roll;
  assign out_yaw_cmd         = state_r.yaw;
  assign out_thrust_cmd      = state_r.thrust;

endmodule

/* sv/scp_chk.sv */
module scp_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_event_res,
  input logic [1:0]         out_request_type,
  input logic               out_request_verbose,
  input logic               out_control_enabled,
  input logic [7:0]         out_ctrl_word,
  input logic signed [11:0] out_pitch_cmd,
  input logic signed [11:0] out_roll_cmd,
  input logic signed [11:0] out_yaw_cmd,
  input logic [11:0]        out_thrust_cmd
);
  import scp_pkg::*;
`include "serial_command_parser_unit_assert.svh"

  logic [61:0] out_word;
  logic        cmd_in_range;

  assign out_word = {out_event_res, out_request_type, out_request_verbose, out_control_enabled,
                     out_ctrl_word, out_pitch_cmd, out_roll_cmd, out_yaw_cmd, out_thrust_cmd};

  assign cmd_in_range = (out_pitch_cmd <= 12'sd2000) && (out_pitch_cmd >= -12'sd2000) &&
                        (out_roll_cmd <= 12'sd2000) && (out_roll_cmd >= -12'sd2000) &&
                        (out_yaw_cmd <= 12'sd1500) && (out_yaw_cmd >= -12'sd1500) &&
                        (out_thrust_cmd <= 12'd3200);

  `SCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `SCP_ASSERT_SAME(a_setpoint_range, out_valid, cmd_in_range)
  `SCP_ASSERT_SAME(a_no_req_fields, out_valid && out_event_res != EV_REQUEST, out_request_type == 2'd0 && !out_request_verbose)
  `SCP_ASSERT_SAME(a_disable_clears, out_valid && out_event_res == EV_DISABLED, !out_control_enabled)
  `SCP_ASSERT_SAME(a_packet_enables, out_valid && out_event_res == EV_PACKET, out_control_enabled)

endmodule

bind serial_command_parser_unit scp_chk u_scp_chk (.*);

/* tb/sv/tb.sv */
module tb;
  import scp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_AFTER_WORDS = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 100;

  localparam logic [1:0] REG_RC_ID     = 2'd0;
  localparam logic [1:0] REG_STATE_ID  = 2'd1;
  localparam logic [1:0] REG_SENSOR_ID = 2'd2;
  localparam logic [1:0] REG_AUX_ID    = 2'd3;

  typedef struct packed {
    event_t      ev;
    logic [1:0]  rtype;
    logic        verb;
    logic        en;
    logic [7:0]  ctrl;
    logic [11:0] pitch;
    logic [11:0] roll;
    logic [11:0] yaw;
    logic [11:0] thrust;
  } parser_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_event_res;
  logic [1:0]  out_request_type;
  logic        out_request_verbose;
  logic        out_control_enabled;
  logic [7:0]  out_ctrl_word;
  logic signed [11:0] out_pitch_cmd;
  logic signed [11:0] out_roll_cmd;
  logic signed [11:0] out_yaw_cmd;
  logic [11:0] out_thrust_cmd;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  serial_command_parser_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_event_res       (out_event_res),
    .out_request_type    (out_request_type),
    .out_request_verbose (out_request_verbose),
    .out_control_enabled (out_control_enabled),
    .out_ctrl_word       (out_ctrl_word),
    .out_pitch_cmd       (out_pitch_cmd),
    .out_roll_cmd        (out_roll_cmd),
    .out_yaw_cmd         (out_yaw_cmd),
    .out_thrust_cmd      (out_thrust_cmd),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  logic [7:0]    rx_backlog[$];
  parser_reply_t reply_forecast[$];

  parse_st_t  mdl_state;
  logic       mdl_verbose;
  logic [3:0] mdl_index;
  logic       mdl_enable;
  logic [7:0] mdl_ctrl;
  logic [15:0] mdl_pitch;
  logic [15:0] mdl_roll;
  logic [15:0] mdl_yaw;
  logic [15:0] mdl_thrust;
  logic [7:0] mdl_ids [NUM_IDS];

  int  cycle_count = 0;
  int  errors = 0;
  int  words_in = 0;
  int  n_requests = 0;
  int  n_disables = 0;
  int  n_packets = 0;
  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  bit  pace_in = 1'b0;
  bit  pace_out = 1'b0;
  int  in_gap = 0;
  int  rx_wait = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] saturate16(logic signed [15:0] v, logic signed [15:0] lo,
                                             logic signed [15:0] hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic parse_word(input logic [7:0] b, output parser_reply_t r);
    int hit;
    r = '0;
    r.ev = EV_NONE;
    case (mdl_state)
      ST_HUNT: begin
        if (b == CH_DOLLAR) mdl_state = ST_REQ1;
        else if (b == CH_HASH) mdl_state = ST_CMD1;
      end
      ST_REQ1: mdl_state = (b == CH_GT) ? ST_REQ2 : ST_HUNT;
      ST_REQ2: begin
        if (b == CH_V && !mdl_verbose) begin
          mdl_verbose = 1'b1;
        end else begin
          hit = -1;
          for (int k = NUM_IDS - 1; k >= 0; k--) begin
            if (b == mdl_ids[k]) hit = k;
          end
          if (hit >= 0) begin
            r.ev = EV_REQUEST;
            r.rtype = hit[1:0];
            r.verb = mdl_verbose;
            mdl_verbose = 1'b0;
          end
          mdl_state = ST_HUNT;
        end
      end
      ST_CMD1: mdl_state = (b == CH_GT) ? ST_CMD2 : ST_HUNT;
      ST_CMD2: begin
        if (b == CH_D) begin
          mdl_enable = 1'b0;
          r.ev = EV_DISABLED;
          mdl_state = ST_HUNT;
        end else if (b == CH_N) begin
          mdl_state = ST_PKT;
        end else begin
          mdl_state = ST_HUNT;
        end
        mdl_index = 4'd0;
      end
      ST_PKT: begin
        mdl_enable = 1'b1;
        case (mdl_index)
          IDX_CTRL:     mdl_ctrl = b;
          IDX_PITCH_LO: mdl_pitch[7:0] = b;
          IDX_PITCH_HI: mdl_pitch[15:8] = b;
          IDX_ROLL_LO:  mdl_roll[7:0] = b;
          IDX_ROLL_HI:  mdl_roll[15:8] = b;
          IDX_YAW_LO:   mdl_yaw[7:0] = b;
          IDX_YAW_HI:   mdl_yaw[15:8] = b;
          IDX_THR_LO:   mdl_thrust[7:0] = b;
          IDX_THR_HI:   mdl_thrust[15:8] = b;
          default: ;
        endcase
        if (mdl_index == IDX_LAST) begin
          mdl_state = ST_HUNT;
          r.ev = EV_PACKET;
        end
        mdl_pitch = saturate16(mdl_pitch, ATT_MIN, ATT_MAX);
        mdl_roll = saturate16(mdl_roll, ATT_MIN, ATT_MAX);
        mdl_yaw = saturate16(mdl_yaw, YAW_MIN, YAW_MAX);
        mdl_thrust = saturate16(mdl_thrust, THRUST_MIN, THRUST_MAX);
        mdl_index = mdl_index + 4'd1;
      end
      default: mdl_state = ST_HUNT;
    endcase
    r.en = mdl_enable;
    r.ctrl = mdl_ctrl;
    r.pitch = mdl_pitch[11:0];
    r.roll = mdl_roll[11:0];
    r.yaw = mdl_yaw[11:0];
    r.thrust = mdl_thrust[11:0];
  endtask

  task automatic check_field(input string name, input logic [11:0] want, input logic [11:0] got);
    if (want !== got) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    parser_reply_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        out_took = 1'b1;
        if (out_event_res == EV_REQUEST) n_requests++;
        if (out_event_res == EV_DISABLED) n_disables++;
        if (out_event_res == EV_PACKET) n_packets++;
        if (reply_forecast.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: result word arrived with nothing expected", $time);
          errors++;
        end else begin
          want = reply_forecast.pop_front();
          check_field("event_res", 12'(want.ev), 12'(out_event_res));
          check_field("request_type", 12'(want.rtype), 12'(out_request_type));
          check_field("request_verbose", 12'(want.verb), 12'(out_request_verbose));
          check_field("control_enabled", 12'(want.en), 12'(out_control_enabled));
          check_field("ctrl_word", 12'(want.ctrl), 12'(out_ctrl_word));
          check_field("pitch_cmd", want.pitch, out_pitch_cmd);
          check_field("roll_cmd", want.roll, out_roll_cmd);
          check_field("yaw_cmd", want.yaw, out_yaw_cmd);
          check_field("thrust_cmd", want.thrust, out_thrust_cmd);
        end
      end
      if (in_valid && !in_stall) begin
        in_took = 1'b1;
        words_in++;
        parse_word(in_rx_byte, want);
        reply_forecast.push_back(want);
      end
    end
  end

  always @(negedge clk) begin
    logic next_valid;
    next_valid = in_valid;
    if (in_took) begin
      next_valid = 1'b0;
      in_took = 1'b0;
    end
    if (rst_n && !next_valid) begin
      if (in_gap != 0) begin
        in_gap--;
      end else if (rx_backlog.size() != 0) begin
        next_valid = 1'b1;
        in_rx_byte <= rx_backlog.pop_front();
        in_gap = (pace_in && $urandom_range(0, 3) != 0) ? $urandom_range(0, 10) : 0;
      end
    end
    in_valid <= next_valid;
  end

  always @(negedge clk) begin
    if (out_took) begin
      out_took = 1'b0;
      rx_wait = (pace_out && $urandom_range(0, 3) != 0) ? $urandom_range(0, 10) : 0;
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait != 0) || (hold_left != 0);
  end

  always @(negedge clk) begin
    if (!hold_done && words_in >= HOLD_AFTER_WORDS) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic set_request_id(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    mdl_ids[idx] = value;
    @(negedge clk);
    check_field("request id readback", 12'(value), prdata[11:0]);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_ids(input logic [7:0] rc, input logic [7:0] st, input logic [7:0] sn,
                             input logic [7:0] aux);
    set_request_id(REG_RC_ID, rc);
    set_request_id(REG_STATE_ID, st);
    set_request_id(REG_SENSOR_ID, sn);
    set_request_id(REG_AUX_ID, aux);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h00, 8'h0F));
      1: return 8'($urandom_range(8'hF0, 8'hFF));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_traffic(input int count);
    int n;
    int kind;
    logic [7:0] seq[$];
    n = 0;
    while (n < count) begin
      seq = {};
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        seq = {CH_DOLLAR, CH_GT};
        if ($urandom_range(0, 2) == 0) seq.push_back(CH_V);
        if ($urandom_range(0, 7) == 0) seq.push_back(CH_V);
        if ($urandom_range(0, 3) != 0) seq.push_back(mdl_ids[$urandom_range(0, NUM_IDS - 1)]);
        else seq.push_back(pick_byte());
      end else if (kind < 50) begin
        seq = {CH_HASH, CH_GT, CH_D};
      end else if (kind < 75) begin
        seq = {CH_HASH, CH_GT, CH_N};
        repeat (10) seq.push_back(pick_byte());
      end else if (kind < 90) begin
        seq.push_back($urandom_range(0, 1) ? CH_DOLLAR : CH_HASH);
        if ($urandom_range(0, 1)) seq.push_back(CH_GT);
        seq.push_back(pick_byte());
      end else begin
        seq.push_back(pick_byte());
      end
      foreach (seq[j]) rx_backlog.push_back(seq[j]);
      n += seq.size();
    end
  endtask

  task automatic wait_idle();
    while (rx_backlog.size() != 0 || in_valid || reply_forecast.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    mdl_state = ST_HUNT;
    mdl_verbose = 1'b0;
    mdl_index = 4'd0;
    mdl_enable = 1'b0;
    mdl_ctrl = 8'd0;
    mdl_pitch = 16'd0;
    mdl_roll = 16'd0;
    mdl_yaw = 16'd0;
    mdl_thrust = 16'd0;
    mdl_ids[0] = RC_ID_RST;
    mdl_ids[1] = STATE_ID_RST;
    mdl_ids[2] = SENSOR_ID_RST;
    mdl_ids[3] = AUX_ID_RST;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A repeated 'v' and an unknown id both leave the verbose flag set for the next request.
    rx_backlog = {CH_DOLLAR, CH_GT, CH_V, CH_V,
                  CH_DOLLAR, CH_GT, 8'hFF,
                  CH_DOLLAR, CH_GT, 8'h02,
                  CH_HASH, CH_GT, CH_D,
                  CH_HASH, CH_GT, CH_N, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F,
                  8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hAA};
    wait_idle();

    program_ids(8'h05, 8'h05, 8'h00, 8'hFF);
    pace_in = 1'b1;
    pace_out = 1'b1;
    queue_traffic(250);
    wait_idle();

    program_ids(CH_V, CH_DOLLAR, 8'hFF, 8'h00);
    pace_in = 1'b0;
    pace_out = 1'b1;
    queue_traffic(250);
    wait_idle();

    program_ids(pick_byte(), pick_byte(), pick_byte(), pick_byte());
    pace_in = 1'b1;
    pace_out = 1'b0;
    queue_traffic(250);
    wait_idle();

    program_ids(RC_ID_RST, STATE_ID_RST, SENSOR_ID_RST, AUX_ID_RST);
    pace_in = 1'b1;
    pace_out = 1'b1;
    queue_traffic(250);
    wait_idle();

    $display("Parsed %0d words under five id settings, with one long output hold.", words_in);
    $display("Results seen: %0d requests, %0d disables, %0d completed packets.",
             n_requests, n_disables, n_packets);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/scp_pkg.sv
sv/scp_step.sv
sv/serial_command_parser_unit.sv
sv/scp_chk.sv
tb/sv/tb.sv
